// ----- rtl/triangle_tangent_frame_defines.svh -----
// Assertion macros for the triangle tangent frame block.
// Included by the files that carry concurrent assertions; no other dependencies.
`ifndef TRIANGLE_TANGENT_FRAME_DEFINES_SVH
`define TRIANGLE_TANGENT_FRAME_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define TTF_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define TTF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TTF_ASSERT(lbl, clk, rstn, prop, msg)
`define TTF_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ----- rtl/ttf_pkg.sv -----
// Shared types and constants for the triangle tangent frame block.
// Used by ttf_unitize and triangle_tangent_frame; depends on nothing.
`default_nettype none
package ttf_pkg;
    localparam int unsigned WideW = 67;
    localparam int unsigned OperW = 33;
    localparam int unsigned ProdW = 66;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_ZERO_DET = 2'd1,
        ST_ZERO_LEN = 2'd2
    } face_status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_ACC,
        S_TAN,
        S_BIT,
        S_FINISH
    } state_t;

    typedef enum logic [2:0] {
        U_IDLE,
        U_CHECK,
        U_SHIFT,
        U_SQ,
        U_SQRT,
        U_DIVI,
        U_DIV,
        U_DONE
    } un_state_t;

    typedef struct packed {
        logic done;
        logic ok;
    } un_status_t;
endpackage
`default_nettype wire

// ----- rtl/ttf_unitize.sv -----
// Iterative unit that scales a wide three-component vector to a Q2.14 unit vector.
// Uses ttf_pkg for its state and status types.
`default_nettype none
module ttf_unitize (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic signed [ttf_pkg::WideW-1:0] vec_in [3],
    output ttf_pkg::un_status_t            status,
    output logic signed [15:0]             comp_out [3]
);
    import ttf_pkg::*;

    un_state_t state_reg, state_next;
    logic [WideW-1:0] m_reg [3];
    logic             ng_reg [3];
    logic             ok_reg;
    logic [63:0]      sum_reg, s_reg, r_reg, bit_reg;
    logic [47:0]      num_reg;
    logic [15:0]      q_reg;
    logic [3:0]       i_reg;
    logic [1:0]       k_reg;
    logic signed [15:0] out_reg [3];

    logic        any_nz, big, tiny, sq_ge, div_ge;
    logic [63:0] sq_trial;
    logic [59:0] sq_prod;
    logic [47:0] div_trial;
    logic [15:0] q_new;
    logic [31:0] len;

    assign any_nz    = (m_reg[0] != '0) || (m_reg[1] != '0) || (m_reg[2] != '0);
    assign big       = (m_reg[0][WideW-1:30] != '0) || (m_reg[1][WideW-1:30] != '0)
                     || (m_reg[2][WideW-1:30] != '0);
    assign tiny      = !m_reg[0][29] && !m_reg[1][29] && !m_reg[2][29];
    assign sq_prod   = m_reg[k_reg][29:0] * m_reg[k_reg][29:0];
    assign sq_trial  = r_reg + bit_reg;
    assign sq_ge     = s_reg >= sq_trial;
    assign len       = r_reg[31:0];
    assign div_trial = 48'(len) << i_reg;
    assign div_ge    = num_reg >= div_trial;
    assign q_new     = q_reg | (div_ge ? (16'd1 << i_reg) : 16'd0);

    assign status.done = (state_reg == U_DONE);
    assign status.ok   = ok_reg;
    assign comp_out    = out_reg;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            U_IDLE:  if (start) state_next = U_CHECK;
            U_CHECK: state_next = any_nz ? U_SHIFT : U_DONE;
            U_SHIFT: if (!big && !tiny) state_next = U_SQ;
            U_SQ:    if (k_reg == 2'd2) state_next = U_SQRT;
            U_SQRT:  if (bit_reg[0]) state_next = U_DIVI;
            U_DIVI:  state_next = U_DIV;
            U_DIV:   if (i_reg == 4'd0) state_next = (k_reg == 2'd2) ? U_DONE : U_DIVI;
            U_DONE:  state_next = U_IDLE;
            default: state_next = U_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= U_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            U_IDLE: begin
                if (start) begin
                    for (int i = 0; i < 3; i++) begin
                        ng_reg[i] <= vec_in[i][WideW-1];
                        m_reg[i]  <= vec_in[i][WideW-1] ? WideW'(-vec_in[i])
                                                        : WideW'(vec_in[i]);
                    end
                end
            end
            U_CHECK: begin
                ok_reg  <= any_nz;
                k_reg   <= 2'd0;
                sum_reg <= '0;
            end
            U_SHIFT: begin
                if (big) begin
                    for (int i = 0; i < 3; i++) m_reg[i] <= m_reg[i] >> 1;
                end else if (tiny) begin
                    for (int i = 0; i < 3; i++) m_reg[i] <= m_reg[i] << 1;
                end
            end
            U_SQ: begin
                sum_reg <= sum_reg + 64'(sq_prod);
                k_reg   <= (k_reg == 2'd2) ? 2'd0 : k_reg + 2'd1;
                if (k_reg == 2'd2) begin
                    s_reg   <= sum_reg + 64'(sq_prod);
                    r_reg   <= '0;
                    bit_reg <= 64'd1 << 62;
                end
            end
            U_SQRT: begin
                if (sq_ge) begin
                    s_reg <= s_reg - sq_trial;
                    r_reg <= (r_reg >> 1) + bit_reg;
                end else begin
                    r_reg <= r_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
            end
            U_DIVI: begin
                num_reg <= 48'({m_reg[k_reg][29:0], 14'd0}) + 48'(len >> 1);
                q_reg   <= '0;
                i_reg   <= 4'd15;
            end
            U_DIV: begin
                if (div_ge) num_reg <= num_reg - div_trial;
                q_reg <= q_new;
                i_reg <= i_reg - 4'd1;
                if (i_reg == 4'd0) begin
                    out_reg[k_reg] <= ng_reg[k_reg] ? -$signed(q_new) : $signed(q_new);
                    k_reg          <= k_reg + 2'd1;
                end
            end
            default: begin
            end
        endcase
    end
endmodule
`default_nettype wire

// ----- rtl/triangle_tangent_frame.sv -----
// Top level of the triangle tangent frame block: corner capture, sequencer, shared multiplier.
// Depends on ttf_pkg, ttf_unitize and triangle_tangent_frame_defines.svh.
`default_nettype none
// Corners are taken one per request; the first two of a triangle are stored in the held
// registers, and the third starts the computation, during which no further corner is
// taken. When both vectors are normalized, the one shared 33 by 33 multiplier first forms
// the determinant and edge combination, the tangent is handed over, the multiplier forms
// the cross product with the normal, and the normalizing unit makes two passes, each made
// of one-bit-per-cycle scaling shifts, a 32-step square root and a 16-step division for
// each component. A zero determinant or a zero tangent ends the computation early.
// A finished result waits in the output register while new corners are taken; a further
// result waits until the receiver has taken the previous one.
module triangle_tangent_frame (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_first_corner,
    input  logic signed [31:0] s_position_x,
    input  logic signed [31:0] s_position_y,
    input  logic signed [31:0] s_position_z,
    input  logic signed [31:0] s_texcoord_u,
    input  logic signed [31:0] s_texcoord_v,
    input  logic signed [15:0] s_normal_x,
    input  logic signed [15:0] s_normal_y,
    input  logic signed [15:0] s_normal_z,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [15:0] m_tangent_x,
    output logic signed [15:0] m_tangent_y,
    output logic signed [15:0] m_tangent_z,
    output logic signed [15:0] m_bitangent_x,
    output logic signed [15:0] m_bitangent_y,
    output logic signed [15:0] m_bitangent_z,
    output logic [1:0]         m_face_status
);
    import ttf_pkg::*;

    `include "triangle_tangent_frame_defines.svh"

    state_t state_reg, state_next;
    logic [1:0]  count_reg, count_eff;
    logic [3:0]  k_reg;
    logic        m_valid_reg, det_neg_reg, out_load, un_start, un_start_reg;
    face_status_t status_reg;

    logic signed [31:0] held_reg [2][5];
    logic signed [31:0] c3_reg [5];
    logic signed [15:0] nrm_reg [3];
    logic signed [15:0] t_reg [3];
    logic signed [15:0] b_reg [3];
    logic signed [WideW-1:0] vec_reg [3];
    logic signed [ProdW-1:0] prod_reg, first_reg;

    logic signed [OperW-1:0] du1, dv1, du2, dv2, op_a, op_b;
    logic signed [OperW-1:0] e1 [3];
    logic signed [OperW-1:0] e2 [3];
    logic signed [ProdW-1:0] prod;
    logic signed [WideW-1:0] diff;
    logic signed [15:0]      un_out [3];
    un_status_t              un_st;

    logic signed [15:0] m_t_reg [3];
    logic signed [15:0] m_b_reg [3];
    logic [1:0]         m_status_reg;

    assign du1 = OperW'(held_reg[1][3]) - OperW'(held_reg[0][3]);
    assign dv1 = OperW'(held_reg[1][4]) - OperW'(held_reg[0][4]);
    assign du2 = OperW'(c3_reg[3]) - OperW'(held_reg[0][3]);
    assign dv2 = OperW'(c3_reg[4]) - OperW'(held_reg[0][4]);
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            e1[i] = OperW'(held_reg[1][i]) - OperW'(held_reg[0][i]);
            e2[i] = OperW'(c3_reg[i]) - OperW'(held_reg[0][i]);
        end
    end

    always_comb begin
        op_a = '0;
        op_b = '0;
        case (k_reg)
            4'd0:  begin op_a = du1; op_b = dv2; end
            4'd1:  begin op_a = du2; op_b = dv1; end
            4'd2:  begin op_a = dv2; op_b = e1[0]; end
            4'd3:  begin op_a = dv1; op_b = e2[0]; end
            4'd4:  begin op_a = dv2; op_b = e1[1]; end
            4'd5:  begin op_a = dv1; op_b = e2[1]; end
            4'd6:  begin op_a = dv2; op_b = e1[2]; end
            4'd7:  begin op_a = dv1; op_b = e2[2]; end
            4'd8:  begin op_a = OperW'(nrm_reg[1]); op_b = OperW'(t_reg[2]); end
            4'd9:  begin op_a = OperW'(nrm_reg[2]); op_b = OperW'(t_reg[1]); end
            4'd10: begin op_a = OperW'(nrm_reg[2]); op_b = OperW'(t_reg[0]); end
            4'd11: begin op_a = OperW'(nrm_reg[0]); op_b = OperW'(t_reg[2]); end
            4'd12: begin op_a = OperW'(nrm_reg[0]); op_b = OperW'(t_reg[1]); end
            4'd13: begin op_a = OperW'(nrm_reg[1]); op_b = OperW'(t_reg[0]); end
            default: begin op_a = '0; op_b = '0; end
        endcase
    end

    assign prod = op_a * op_b;
    assign diff = WideW'(first_reg) - WideW'(prod_reg);

    ttf_unitize u_unitize (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (un_start),
        .vec_in   (vec_reg),
        .status   (un_st),
        .comp_out (un_out)
    );

    always_comb begin
        state_next = state_reg;
        s_ready    = (state_reg == S_IDLE);
        count_eff  = s_first_corner ? 2'd0 : count_reg;
        un_start   = un_start_reg;
        out_load   = (state_reg == S_FINISH) && (!m_valid_reg || m_ready);
        case (state_reg)
            S_IDLE:   if (s_valid && count_eff == 2'd2) state_next = S_MUL;
            S_MUL:    state_next = S_ACC;
            S_ACC: begin
                if (k_reg == 4'd1 && diff == '0) begin
                    state_next = S_FINISH;
                end else if (k_reg == 4'd7) begin
                    state_next = S_TAN;
                end else if (k_reg == 4'd13) begin
                    state_next = S_BIT;
                end else begin
                    state_next = S_MUL;
                end
            end
            S_TAN:    if (un_st.done) state_next = un_st.ok ? S_MUL : S_FINISH;
            S_BIT:    if (un_st.done) state_next = S_FINISH;
            S_FINISH: if (out_load) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= 2'd0;
            m_valid_reg  <= 1'b0;
            un_start_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            un_start_reg <= (state_reg == S_ACC) && ((k_reg == 4'd7) || (k_reg == 4'd13));
            if (s_valid && s_ready) begin
                count_reg <= (count_eff == 2'd2) ? 2'd0 : count_eff + 2'd1;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    if (count_eff != 2'd2) begin
                        held_reg[count_eff[0]][0] <= s_position_x;
                        held_reg[count_eff[0]][1] <= s_position_y;
                        held_reg[count_eff[0]][2] <= s_position_z;
                        held_reg[count_eff[0]][3] <= s_texcoord_u;
                        held_reg[count_eff[0]][4] <= s_texcoord_v;
                    end else begin
                        c3_reg[0]  <= s_position_x;
                        c3_reg[1]  <= s_position_y;
                        c3_reg[2]  <= s_position_z;
                        c3_reg[3]  <= s_texcoord_u;
                        c3_reg[4]  <= s_texcoord_v;
                        nrm_reg[0] <= s_normal_x;
                        nrm_reg[1] <= s_normal_y;
                        nrm_reg[2] <= s_normal_z;
                        k_reg      <= 4'd0;
                        status_reg <= ST_OK;
                    end
                end
            end
            S_MUL: prod_reg <= prod;
            S_ACC: begin
                k_reg <= k_reg + 4'd1;
                case (k_reg)
                    4'd1: begin
                        det_neg_reg <= diff[WideW-1];
                        if (diff == '0) status_reg <= ST_ZERO_DET;
                    end
                    4'd3:  vec_reg[0] <= diff;
                    4'd5:  vec_reg[1] <= diff;
                    4'd7:  vec_reg[2] <= diff;
                    4'd9:  vec_reg[0] <= diff;
                    4'd11: vec_reg[1] <= diff;
                    4'd13: vec_reg[2] <= diff;
                    default: first_reg <= prod_reg;
                endcase
            end
            S_TAN: begin
                if (un_st.done) begin
                    if (un_st.ok) begin
                        for (int i = 0; i < 3; i++) begin
                            t_reg[i] <= det_neg_reg ? -un_out[i] : un_out[i];
                        end
                    end else begin
                        status_reg <= ST_ZERO_LEN;
                    end
                end
            end
            S_BIT: begin
                if (un_st.done) begin
                    if (un_st.ok) begin
                        b_reg <= un_out;
                    end else begin
                        status_reg <= ST_ZERO_LEN;
                    end
                end
            end
            default: begin
            end
        endcase
        if (out_load) begin
            for (int i = 0; i < 3; i++) begin
                m_t_reg[i] <= (status_reg == ST_OK) ? t_reg[i] : 16'sd0;
                m_b_reg[i] <= (status_reg == ST_OK) ? b_reg[i] : 16'sd0;
            end
            m_status_reg <= status_reg;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_tangent_x   = m_t_reg[0];
    assign m_tangent_y   = m_t_reg[1];
    assign m_tangent_z   = m_t_reg[2];
    assign m_bitangent_x = m_b_reg[0];
    assign m_bitangent_y = m_b_reg[1];
    assign m_bitangent_z = m_b_reg[2];
    assign m_face_status = m_status_reg;

    `TTF_ASSERT(a_load_from_finish, aclk, aresetn, $rose(m_valid_reg) |-> $past(state_reg == S_FINISH), "result loaded outside the finish state")
    `TTF_ASSERT(a_third_starts, aclk, aresetn, (s_valid && s_ready && count_eff == 2'd2) |=> (state_reg == S_MUL), "third corner did not start the computation")
    `TTF_ASSERT(a_fail_zero, aclk, aresetn, (m_valid_reg && m_status_reg != ST_OK) |-> (m_t_reg[0] == 16'sd0 && m_b_reg[2] == 16'sd0), "failed face carries non-zero vectors")
    `TTF_ASSERT(a_busy_not_ready, aclk, aresetn, (state_reg != S_IDLE) |-> !s_ready, "request taken while computing")
endmodule
`default_nettype wire

// ----- tb/tb.sv -----
// Testbench for triangle_tangent_frame: directed corners, then random triangles and noise.
// Results are checked against an in-bench tangent frame calculation; depends on ttf_pkg.
`timescale 1ns / 1ps
module tb;
    import ttf_pkg::*;

    typedef struct {
        bit                 first;
        logic signed [31:0] px, py, pz, tu, tv;
        logic signed [15:0] nx, ny, nz;
    } corner_t;

    typedef struct {
        logic signed [15:0] t[3];
        logic signed [15:0] b[3];
        face_status_t       st;
    } frame_t;

    typedef struct {
        corner_t      c;
        bit           typed;
        face_status_t st;
    } row_t;

    localparam logic signed [31:0] ONE = 32'sd65536;
    localparam logic signed [31:0] PMAX = 32'sh7fffffff;
    localparam logic signed [31:0] PMIN = 32'sh80000000;
    localparam int WATCHDOG_LIMIT = 50000;

    logic               aclk = 1'b0;
    logic               aresetn;
    logic               s_valid, s_ready, s_first_corner;
    logic signed [31:0] s_position_x, s_position_y, s_position_z, s_texcoord_u, s_texcoord_v;
    logic signed [15:0] s_normal_x, s_normal_y, s_normal_z;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic signed [15:0] m_tangent_x, m_tangent_y, m_tangent_z;
    logic signed [15:0] m_bitangent_x, m_bitangent_y, m_bitangent_z;
    logic [1:0]         m_face_status;

    frame_t  frames_due[$];
    row_t    rows[$];
    corner_t held[2];
    int      corners_held;
    int      errors;
    int      send_idle_pct, recv_idle_pct;
    int      quiet_cycles = 0;

    always #6 aclk = ~aclk;

    triangle_tangent_frame dut (.*);

    function automatic logic [63:0] floor_sqrt(logic [63:0] s);
        logic [63:0] r, bt;
        r = 0;
        bt = 64'd1 << 62;
        while (bt > s) bt >>= 2;
        while (bt != 0) begin
            if (s >= r + bt) begin
                s -= r + bt;
                r = (r >> 1) + bt;
            end else begin
                r >>= 1;
            end
            bt >>= 2;
        end
        return r;
    endfunction

    // Scale to a common power of two, then round each component of the unit vector.
    function automatic bit unit_vector(input logic signed [127:0] c[3],
                                       output logic signed [15:0] o[3]);
        logic [127:0] m[3];
        bit           neg[3];
        logic [63:0]  sum, len, q;
        sum = 0;
        for (int i = 0; i < 3; i++) begin
            neg[i] = c[i] < 0;
            m[i] = neg[i] ? -c[i] : c[i];
        end
        if (m[0] == 0 && m[1] == 0 && m[2] == 0) return 0;
        while (m[0] >= (128'd1 << 30) || m[1] >= (128'd1 << 30) || m[2] >= (128'd1 << 30))
            for (int i = 0; i < 3; i++) m[i] >>= 1;
        while (m[0] < (128'd1 << 29) && m[1] < (128'd1 << 29) && m[2] < (128'd1 << 29))
            for (int i = 0; i < 3; i++) m[i] <<= 1;
        for (int i = 0; i < 3; i++) sum += m[i][63:0] * m[i][63:0];
        len = floor_sqrt(sum);
        for (int i = 0; i < 3; i++) begin
            q = (m[i][63:0] * 64'd16384 + len / 2) / len;
            o[i] = neg[i] ? -q[15:0] : q[15:0];
        end
        return 1;
    endfunction

    // Returns 1 and the frame when the corner closes a triangle.
    function automatic bit tangent_frame_of(input corner_t c, output frame_t f);
        logic signed [127:0] du1, dv1, du2, dv2, det;
        logic signed [127:0] e1[3], e2[3], w[3], cr[3];
        logic signed [15:0]  nrm[3];
        longint              v;
        int                  j, l;
        if (c.first) corners_held = 0;
        if (corners_held < 2) begin
            held[corners_held] = c;
            corners_held++;
            return 0;
        end
        corners_held = 0;
        nrm = '{c.nx, c.ny, c.nz};
        du1 = longint'(held[1].tu) - longint'(held[0].tu);
        dv1 = longint'(held[1].tv) - longint'(held[0].tv);
        du2 = longint'(c.tu) - longint'(held[0].tu);
        dv2 = longint'(c.tv) - longint'(held[0].tv);
        det = du1 * dv2 - du2 * dv1;
        e1 = '{longint'(held[1].px) - longint'(held[0].px),
               longint'(held[1].py) - longint'(held[0].py),
               longint'(held[1].pz) - longint'(held[0].pz)};
        e2 = '{longint'(c.px) - longint'(held[0].px),
               longint'(c.py) - longint'(held[0].py),
               longint'(c.pz) - longint'(held[0].pz)};
        f.st = ST_OK;
        if (det == 0) begin
            f.st = ST_ZERO_DET;
        end else begin
            for (int i = 0; i < 3; i++) w[i] = dv2 * e1[i] - dv1 * e2[i];
            if (!unit_vector(w, f.t)) begin
                f.st = ST_ZERO_LEN;
            end else begin
                if (det < 0)
                    for (int i = 0; i < 3; i++) f.t[i] = -f.t[i];
                for (int i = 0; i < 3; i++) begin
                    j = (i + 1) % 3;
                    l = (i + 2) % 3;
                    v = longint'(nrm[j]) * longint'(f.t[l]) - longint'(nrm[l]) * longint'(f.t[j]);
                    cr[i] = v;
                end
                if (!unit_vector(cr, f.b)) f.st = ST_ZERO_LEN;
            end
        end
        if (f.st != ST_OK)
            for (int i = 0; i < 3; i++) begin
                f.t[i] = 0;
                f.b[i] = 0;
            end
        return 1;
    endfunction

    function automatic corner_t mk(bit first, logic signed [31:0] px, py, pz, tu, tv,
                                   logic signed [15:0] nx = 0, ny = 0, nz = 16384);
        corner_t c;
        c = '{first, px, py, pz, tu, tv, nx, ny, nz};
        return c;
    endfunction

    function automatic void add_row(corner_t c, bit typed = 0, face_status_t st = ST_OK);
        row_t r;
        r = '{c, typed, st};
        rows.push_back(r);
    endfunction

    task automatic send_corner(corner_t c, bit typed = 0, face_status_t st = ST_OK);
        frame_t f;
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_valid        <= 1'b1;
        s_first_corner <= c.first;
        s_position_x   <= c.px;
        s_position_y   <= c.py;
        s_position_z   <= c.pz;
        s_texcoord_u   <= c.tu;
        s_texcoord_v   <= c.tv;
        s_normal_x     <= c.nx;
        s_normal_y     <= c.ny;
        s_normal_z     <= c.nz;
        do @(posedge aclk); while (!(s_valid && s_ready));
        if (tangent_frame_of(c, f)) begin
            if (typed) begin
                f.t = '{0, 0, 0};
                f.b = '{0, 0, 0};
                f.st = st;
            end
            frames_due.push_back(f);
        end
    endtask

    function automatic logic signed [31:0] rand_coord(int spread);
        case (spread)
            0: return $urandom;
            1: return $signed($urandom_range(16 * 65536)) - 8 * 65536;
            default: return $signed($urandom_range(64)) - 32;
        endcase
    endfunction

    function automatic corner_t rand_corner(bit first, int spread);
        corner_t c;
        c.first = first;
        c.px = rand_coord(spread);
        c.py = rand_coord(spread);
        c.pz = rand_coord(spread);
        c.tu = rand_coord(spread);
        c.tv = rand_coord(spread);
        if ($urandom_range(9) == 0) begin
            c.nx = 16'($urandom);
            c.ny = 16'($urandom);
            c.nz = 16'($urandom);
        end else begin
            c.nx = 16'($signed($urandom_range(32768)) - 16384);
            c.ny = 16'($signed($urandom_range(32768)) - 16384);
            c.nz = 16'($signed($urandom_range(32768)) - 16384);
        end
        return c;
    endfunction

    task automatic random_phase(int n, int s_pct, int r_pct);
        corner_t c;
        int      sent, spread;
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        sent = 0;
        while (sent < n) begin
            if ($urandom_range(99) < 85) begin
                spread = $urandom_range(2);
                for (int k = 0; k < 3; k++) begin
                    c = rand_corner(k == 0, spread);
                    if (k == 2 && $urandom_range(19) == 0) begin
                        c.tu = held[0].tu;
                        c.tv = held[0].tv;
                    end
                    send_corner(c);
                end
                sent += 3;
            end else begin
                send_corner(rand_corner($urandom_range(1), $urandom_range(2)));
                sent++;
            end
        end
    endtask

    task automatic check_field(string name, int expected, int actual);
        if (expected != actual) begin
            $error("%s: expected %0d, actual %0d", name, expected, actual);
            errors++;
        end
    endtask

    always @(posedge aclk) begin
        m_ready <= $urandom_range(99) >= recv_idle_pct;
    end

    always @(posedge aclk) begin
        frame_t f;
        if (aresetn && m_valid && m_ready) begin
            if (frames_due.size() == 0) begin
                $error("result with no triangle outstanding");
                errors++;
            end else begin
                f = frames_due.pop_front();
                check_field("tangent_x", f.t[0], m_tangent_x);
                check_field("tangent_y", f.t[1], m_tangent_y);
                check_field("tangent_z", f.t[2], m_tangent_z);
                check_field("bitangent_x", f.b[0], m_bitangent_x);
                check_field("bitangent_y", f.b[1], m_bitangent_y);
                check_field("bitangent_z", f.b[2], m_bitangent_z);
                check_field("face_status", f.st, m_face_status);
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    initial begin
        corners_held = 0;
        errors = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_first_corner <= 1'b0;
        s_position_x <= 0;
        s_position_y <= 0;
        s_position_z <= 0;
        s_texcoord_u <= 0;
        s_texcoord_v <= 0;
        s_normal_x <= 0;
        s_normal_y <= 0;
        s_normal_z <= 0;

        // A plain triangle.
        add_row(mk(1, 0, 0, 0, 0, 0));
        add_row(mk(0, ONE, 0, 0, ONE, 0));
        add_row(mk(0, 0, ONE, 0, 0, ONE));
        // Texture coordinates all equal, so the determinant vanishes.
        add_row(mk(1, 0, 0, 0, ONE, ONE));
        add_row(mk(0, ONE, 0, 0, ONE, ONE));
        add_row(mk(0, 0, ONE, 0, ONE, ONE), 1, ST_ZERO_DET);
        // Coincident positions give a zero tangent.
        add_row(mk(1, ONE, ONE, ONE, 0, 0));
        add_row(mk(0, ONE, ONE, ONE, ONE, 0));
        add_row(mk(0, ONE, ONE, ONE, 0, ONE), 1, ST_ZERO_LEN);
        // Normal parallel to the tangent.
        add_row(mk(1, 0, 0, 0, 0, 0));
        add_row(mk(0, ONE, 0, 0, ONE, 0));
        add_row(mk(0, 0, ONE, 0, 0, ONE, 16384, 0, 0), 1, ST_ZERO_LEN);
        // Zero normal.
        add_row(mk(1, 0, 0, 0, 0, 0));
        add_row(mk(0, ONE, 0, 0, ONE, 0));
        add_row(mk(0, 0, ONE, 0, 0, ONE, 0, 0, 0), 1, ST_ZERO_LEN);
        // Field extremes.
        add_row(mk(1, PMAX, PMIN, PMAX, PMIN, PMIN));
        add_row(mk(0, PMIN, PMAX, PMIN, PMAX, PMIN));
        add_row(mk(0, PMAX, PMAX, PMIN, PMIN, PMAX, -16384, 16384, 0));
        // A restart discards the two corners held before it.
        add_row(mk(1, 5 * ONE, 0, 0, 3 * ONE, 0));
        add_row(mk(0, 0, 7 * ONE, 0, 0, ONE));
        add_row(mk(1, 0, 0, ONE, 0, 0));
        add_row(mk(0, 0, ONE, 0, -ONE, ONE));
        add_row(mk(0, ONE, 0, 0, ONE, ONE, 0, 16384, 0));
        // Normal outside the unit range.
        add_row(mk(1, 0, 0, 0, 0, 0));
        add_row(mk(0, 3 * ONE, ONE, 0, ONE, 2 * ONE));
        add_row(mk(0, 0, 2 * ONE, ONE, 2 * ONE, -ONE, -32768, 32767, 12345));

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_idle_pct = 21;
        recv_idle_pct = 67;
        foreach (rows[i]) send_corner(rows[i].c, rows[i].typed, rows[i].st);

        random_phase(630, 21, 67);
        s_valid <= 1'b0;
        while (frames_due.size() != 0) @(posedge aclk);
        random_phase(630, 67, 21);
        random_phase(640, 0, 0);
        s_valid <= 1'b0;

        while (frames_due.size() != 0) @(posedge aclk);
        repeat (400) @(posedge aclk);
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
